@@ hdl/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and types for the RGB Sobel edge magnitude core.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [20:0] MAG_SAT_LIMIT = 21'd65280;

  typedef struct packed {
    logic       grad;
    logic       sq;
    logic       step;
    logic [7:0] root_bit;
  } sem_ctrl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sem_pix_if.sv @@
// ----------------------------------------------------------------------------
// sem_pix_if
// Input pixel channel: valid/ready with opcode and RGB components.
// ----------------------------------------------------------------------------
`default_nettype none

interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

@@ hdl/sem_edge_if.sv @@
// ----------------------------------------------------------------------------
// sem_edge_if
// Output result channel: valid/ready with RGB edge magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sem_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_edge;
  logic [7:0] green_edge;
  logic [7:0] blue_edge;
  logic       frame_last;

  modport source (output valid, red_edge, green_edge, blue_edge, frame_last, input ready);
  modport sink   (input valid, red_edge, green_edge, blue_edge, frame_last, output ready);
endinterface

`default_nettype wire

@@ hdl/sem_chan.sv @@
// ----------------------------------------------------------------------------
// sem_chan
// One color channel: Sobel gradients, sum of squares, bit-serial rounded
// square root saturated at 255.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_chan (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sem_pkg::sem_ctrl_t  ctrl_i,
  input  wire logic [8:0][7:0]     pix_i,
  output logic [7:0]               mag_o
);

  logic [9:0]  ax_q, ay_q;
  logic [20:0] s_q;
  logic [7:0]  n_q;

  logic signed [12:0] gx, gy;
  logic [9:0]  ax_d, ay_d;
  logic [7:0]  t;
  logic [15:0] tt;
  logic [16:0] nn;

  always_comb begin
    gx = 13'(signed'({5'd0, pix_i[2]})) - 13'(signed'({5'd0, pix_i[0]}))
       + 13'(signed'({4'd0, pix_i[5], 1'b0})) - 13'(signed'({4'd0, pix_i[3], 1'b0}))
       + 13'(signed'({5'd0, pix_i[8]})) - 13'(signed'({5'd0, pix_i[6]}));
    gy = 13'(signed'({5'd0, pix_i[6]})) - 13'(signed'({5'd0, pix_i[0]}))
       + 13'(signed'({4'd0, pix_i[7], 1'b0})) - 13'(signed'({4'd0, pix_i[1], 1'b0}))
       + 13'(signed'({5'd0, pix_i[8]})) - 13'(signed'({5'd0, pix_i[2]}));
    ax_d = gx[12] ? 10'(-gx) : gx[9:0];
    ay_d = gy[12] ? 10'(-gy) : gy[9:0];
    t    = n_q | ctrl_i.root_bit;
    tt   = 16'(t) * 16'(t);
    nn   = 17'(n_q) * 17'(n_q) + 17'(n_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.grad) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
    if (ctrl_i.sq) begin
      s_q <= 21'(ax_q) * 21'(ax_q) + 21'(ay_q) * 21'(ay_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (ctrl_i.sq) begin
      n_q <= '0;
    end else if (ctrl_i.step && (21'(tt) <= s_q)) begin
      n_q <= t;
    end
  end

  always_comb begin
    if (s_q > sem_pkg::MAG_SAT_LIMIT) begin
      mag_o = 8'd255;
    end else if (s_q > 21'(nn)) begin
      mag_o = n_q + 8'd1;
    end else begin
      mag_o = n_q;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sobel_edge_magnitude_rgb_core.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// Streaming 3x3 Sobel gradient magnitude per RGB channel, line store in RAM.
//
// Pixels enter on pix_i in raster order (opcode pixel); the result for pixel
// k leaves on edge_o when item k+width+1 is taken, so width+1 drain items
// flush a frame after its last pixel. Out-of-frame neighbors count as zero.
// frame_last marks the final result of a frame; counters then restart.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 frame width, 1 frame height); a change mid-frame re-derives the
// column/row position with a serial divider before the next item.
// Sequencing: one item at a time. An item reads the column RAM, writes back
// and shifts the window, then for items that give a result: gradients,
// squares, 8-step root, output load. The output register holds a result
// until edge_o.ready; a new item is taken meanwhile, but the next result
// waits in the final step while stalled.
// Reset: width 640, height 480, window zero, counters zero; RAM undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_rgb_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [sem_pkg::DIM_W-1:0]         cfg_data_i,
  sem_pix_if.sink                                pix_i,
  sem_edge_if.source                             edge_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_WB   = 8'b0000_1000,
    S_GRAD = 8'b0001_0000,
    S_SQ   = 8'b0010_0000,
    S_ROOT = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  localparam int unsigned DIM_W = sem_pkg::DIM_W;
  localparam int unsigned CNT_W = sem_pkg::CNT_W;
  localparam int unsigned COL_W = sem_pkg::COL_W;
  localparam int unsigned PIX_W = sem_pkg::PIX_W;

  state_e state_q, state_d;

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] wc, hc;
  logic [CNT_W-1:0] total, limit;

  logic [CNT_W-1:0] items_q;
  logic [COL_W-1:0] kcol_q;
  logic [DIM_W-1:0] krow_q;
  logic             need_div_q;

  logic [CNT_W-1:0] dvd_q;
  logic [DIM_W-1:0] rem_q;
  logic [4:0]       div_cnt_q;
  logic [DIM_W:0]   rem_sh;
  logic             rem_ge;

  logic [PIX_W-1:0] px_q;
  logic [PIX_W-1:0] win_q [9];
  logic [8:0]       ok_q;
  logic             last_q;
  logic [2:0]       root_cnt_q;

  logic [2*PIX_W-1:0] line_mem [sem_pkg::MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic             wrap, take;
  logic [CNT_W-1:0] k_eff;
  logic             has_res;
  logic [DIM_W-1:0] pr, pc;
  logic             rok0, rok2, cok0, cok2, p_last;
  logic [8:0]       ok_d;

  sem_pkg::sem_ctrl_t ctrl;
  logic [8:0][7:0]    ch_r, ch_g, ch_b;
  logic [7:0]         mag_r, mag_g, mag_b;

  logic       out_valid_q, out_last_q;
  logic [7:0] out_r_q, out_g_q, out_b_q;
  logic       out_free;

  assign wc    = sem_pkg::clamp_dim(width_q, DIM_W'(sem_pkg::MAX_WIDTH));
  assign hc    = sem_pkg::clamp_dim(height_q, DIM_W'(sem_pkg::MAX_HEIGHT));
  assign total = CNT_W'(wc) * CNT_W'(hc);
  assign limit = total + CNT_W'(wc);

  assign wrap  = items_q > limit;
  assign k_eff = wrap ? '0 : items_q;
  assign take  = (pix_i.opcode == sem_pkg::OP_DRAIN) ? (k_eff >= total) : (k_eff < total);

  assign rem_sh = {rem_q, dvd_q[CNT_W-1]};
  assign rem_ge = rem_sh >= {1'b0, wc};

  assign has_res = items_q >= (CNT_W'(wc) + CNT_W'(1));
  assign pr      = (kcol_q == '0) ? (krow_q - DIM_W'(2)) : (krow_q - DIM_W'(1));
  assign pc      = (kcol_q == '0) ? (wc - DIM_W'(1)) : (DIM_W'(kcol_q) - DIM_W'(1));
  assign rok0    = pr != '0;
  assign rok2    = pr < (hc - DIM_W'(1));
  assign cok0    = pc != '0;
  assign cok2    = pc < (wc - DIM_W'(1));
  assign p_last  = (pr == hc - DIM_W'(1)) && (pc == wc - DIM_W'(1));
  assign ok_d    = {rok2 & cok2, rok2, rok2 & cok0,
                    cok2, 1'b1, cok0,
                    rok0 & cok2, rok0, rok0 & cok0};

  assign out_free    = !out_valid_q || edge_o.ready;
  assign pix_i.ready = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pix_i.valid && take) begin
          state_d = (need_div_q && !wrap) ? S_DIV : S_RD;
        end
      end
      S_DIV:  if (div_cnt_q == 5'(CNT_W - 1)) state_d = S_RD;
      S_RD:   state_d = S_WB;
      S_WB:   state_d = has_res ? S_GRAD : S_IDLE;
      S_GRAD: state_d = S_SQ;
      S_SQ:   state_d = S_ROOT;
      S_ROOT: if (root_cnt_q == 3'd7) state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.grad     = state_q == S_GRAD;
    ctrl.sq       = state_q == S_SQ;
    ctrl.step     = state_q == S_ROOT;
    ctrl.root_bit = 8'h80 >> root_cnt_q;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ch_r[i] = ok_q[i] ? win_q[i][23:16] : 8'd0;
      ch_g[i] = ok_q[i] ? win_q[i][15:8]  : 8'd0;
      ch_b[i] = ok_q[i] ? win_q[i][7:0]   : 8'd0;
    end
  end

  sem_chan u_chan_r (.clk_i, .rst_ni, .ctrl_i(ctrl), .pix_i(ch_r), .mag_o(mag_r));
  sem_chan u_chan_g (.clk_i, .rst_ni, .ctrl_i(ctrl), .pix_i(ch_g), .mag_o(mag_g));
  sem_chan u_chan_b (.clk_i, .rst_ni, .ctrl_i(ctrl), .pix_i(ch_b), .mag_o(mag_b));

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rd_q <= line_mem[kcol_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WB) begin
      line_mem[kcol_q] <= {rd_q[PIX_W-1:0], px_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pix_i.valid) begin
      px_q <= (pix_i.opcode == sem_pkg::OP_DRAIN) ? '0
            : {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
    end
    if (state_q == S_WB) begin
      ok_q   <= ok_d;
      last_q <= p_last;
    end
    if (state_q == S_FIN && out_free) begin
      out_r_q    <= mag_r;
      out_g_q    <= mag_g;
      out_b_q    <= mag_b;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= DIM_W'(640);
      height_q    <= DIM_W'(480);
      items_q     <= '0;
      kcol_q      <= '0;
      krow_q      <= '0;
      need_div_q  <= 1'b0;
      dvd_q       <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      root_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sem_pkg::REG_FRAME_WIDTH:  begin
            width_q    <= cfg_data_i;
            need_div_q <= 1'b1;
          end
          sem_pkg::REG_FRAME_HEIGHT: begin
            height_q   <= cfg_data_i;
            need_div_q <= 1'b1;
          end
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (pix_i.valid) begin
            if (wrap) begin
              items_q    <= '0;
              kcol_q     <= '0;
              krow_q     <= '0;
              need_div_q <= 1'b0;
            end
            dvd_q     <= items_q;
            rem_q     <= '0;
            div_cnt_q <= '0;
          end
        end
        S_DIV: begin
          dvd_q     <= {dvd_q[CNT_W-2:0], rem_ge};
          rem_q     <= rem_ge ? DIM_W'(rem_sh - {1'b0, wc}) : rem_sh[DIM_W-1:0];
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'(CNT_W - 1)) begin
            kcol_q     <= rem_ge ? COL_W'(rem_sh - {1'b0, wc}) : rem_sh[COL_W-1:0];
            krow_q     <= {dvd_q[DIM_W-2:0], rem_ge};
            need_div_q <= 1'b0;
          end
        end
        S_WB: begin
          for (int i = 0; i < 3; i++) begin
            win_q[i*3]   <= win_q[i*3+1];
            win_q[i*3+1] <= win_q[i*3+2];
          end
          win_q[2] <= rd_q[2*PIX_W-1:PIX_W];
          win_q[5] <= rd_q[PIX_W-1:0];
          win_q[8] <= px_q;
          if (has_res && p_last) begin
            items_q <= '0;
            kcol_q  <= '0;
            krow_q  <= '0;
          end else begin
            items_q <= items_q + CNT_W'(1);
            if (DIM_W'(kcol_q) + DIM_W'(1) >= wc) begin
              kcol_q <= '0;
              krow_q <= krow_q + DIM_W'(1);
            end else begin
              kcol_q <= kcol_q + COL_W'(1);
            end
          end
        end
        S_SQ:   root_cnt_q <= '0;
        S_ROOT: root_cnt_q <= root_cnt_q + 3'd1;
        default: ;
      endcase
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (edge_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign edge_o.valid      = out_valid_q;
  assign edge_o.red_edge   = out_r_q;
  assign edge_o.green_edge = out_g_q;
  assign edge_o.blue_edge  = out_b_q;
  assign edge_o.frame_last = out_last_q;

endmodule

`default_nettype wire

@@ tb/sem_edge_checker.sv @@
// ----------------------------------------------------------------------------
// sem_edge_checker
// Watches the pixel and edge channels and the register port of the Sobel core,
// predicts every edge result from the accepted pixel transfers and compares
// each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_edge_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sem_pkg::DIM_W-1:0]     cfg_data_i,
  sem_pix_if                                 pix,
  sem_edge_if                                edge_if,
  output int                                 pending_o,
  output int                                 errors_o
);

  localparam int unsigned PIX_W      = sem_pkg::PIX_W;
  localparam int unsigned DIM_W      = sem_pkg::DIM_W;
  localparam int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH;
  localparam int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_res_t;

  logic [PIX_W-1:0] row_prev[MAX_WIDTH];
  logic [PIX_W-1:0] row_prev2[MAX_WIDTH];
  logic [PIX_W-1:0] win[9];
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  int unsigned      taken;
  edge_res_t        edge_expected[$];

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  function automatic logic [7:0] rounded_root(input int unsigned s);
    int unsigned n;
    n = 0;
    if (s > 65280) return 8'd255;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  function automatic logic [7:0] channel_mag(input int sh, input logic [8:0] ok);
    int v[9];
    int gx, gy;
    for (int i = 0; i < 9; i++) v[i] = ok[i] ? int'((win[i] >> sh) & 24'hFF) : 0;
    gx = -v[0] + v[2] - 2 * v[3] + 2 * v[5] - v[6] + v[8];
    gy = -v[0] - 2 * v[1] - v[2] + v[6] + 2 * v[7] + v[8];
    return rounded_root(gx * gx + gy * gy);
  endfunction

  task automatic take_item(input logic op, input logic [PIX_W-1:0] rgb);
    int unsigned w, h, total, k, col, p, r, c;
    logic [PIX_W-1:0] px, top, mid;
    logic [8:0] ok;
    edge_res_t res;
    w = eff_dim(width_q, MAX_WIDTH);
    h = eff_dim(height_q, MAX_HEIGHT);
    total = w * h;
    if (taken > total + w) taken = 0;
    k = taken;
    if (op == sem_pkg::OP_PIXEL) begin
      if (k >= total) return;
      px = rgb;
    end else begin
      if (k < total) return;
      px = '0;
    end
    col = k % w;
    top = row_prev2[col];
    mid = row_prev[col];
    row_prev2[col] = mid;
    row_prev[col] = px;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    taken = k + 1;
    if (k < w + 1) return;
    p = k - w - 1;
    r = p / w;
    c = p % w;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ok[i*3+j] = ((i == 0) ? (r > 0) : (i == 2) ? (r + 1 < h) : 1'b1) &&
                    ((j == 0) ? (c > 0) : (j == 2) ? (c + 1 < w) : 1'b1);
      end
    end
    res.red = channel_mag(16, ok);
    res.green = channel_mag(8, ok);
    res.blue = channel_mag(0, ok);
    res.last = (p + 1 == total);
    edge_expected.push_back(res);
    if (p + 1 >= total) taken = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_res_t want;
    if (!rst_ni) begin
      width_q <= DIM_W'(640);
      height_q <= DIM_W'(480);
      taken = 0;
      for (int i = 0; i < 9; i++) win[i] = '0;
      edge_expected.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == sem_pkg::REG_FRAME_WIDTH) width_q <= cfg_data_i;
        else if (cfg_idx_i == sem_pkg::REG_FRAME_HEIGHT) height_q <= cfg_data_i;
      end
      if (pix.valid && pix.ready) take_item(pix.opcode, {pix.red_in, pix.green_in, pix.blue_in});
      if (edge_if.valid && edge_if.ready) begin
        if (edge_expected.size() == 0) begin
          $error("unexpected edge transfer");
          errors_o++;
        end else begin
          want = edge_expected.pop_front();
          if (edge_if.red_edge !== want.red) begin
            $error("red_edge: expected %0d, got %0d", want.red, edge_if.red_edge);
            errors_o++;
          end
          if (edge_if.green_edge !== want.green) begin
            $error("green_edge: expected %0d, got %0d", want.green, edge_if.green_edge);
            errors_o++;
          end
          if (edge_if.blue_edge !== want.blue) begin
            $error("blue_edge: expected %0d, got %0d", want.blue, edge_if.blue_edge);
            errors_o++;
          end
          if (edge_if.frame_last !== want.last) begin
            $error("frame_last: expected %0d, got %0d", want.last, edge_if.frame_last);
            errors_o++;
          end
        end
      end
      pending_o = edge_expected.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_sobel_edge_magnitude_rgb_core.sv @@
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_rgb_core
// Drives frames of RGB pixels and drain items into the Sobel core with random
// gaps and output stalls, across many small frame sizes including zero sizes,
// ignored drains and surplus pixels, and partial frames cut by a size change.
// A checker beside the core predicts and compares all results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sobel_edge_magnitude_rgb_core;

  localparam int unsigned PIX_W      = sem_pkg::PIX_W;
  localparam int unsigned DIM_W      = sem_pkg::DIM_W;
  localparam int unsigned CFG_IDX_W  = sem_pkg::CFG_IDX_W;
  localparam int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH;
  localparam int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0]     cfg_data;
  int                   pending;
  int                   errors;
  int                   items_sent;
  bit                   quiet;
  int                   stall_left;

  sem_pix_if  pix();
  sem_edge_if edge_if();

  sobel_edge_magnitude_rgb_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .edge_o     (edge_if)
  );

  sem_edge_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix        (pix),
    .edge_if    (edge_if),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (quiet || r < 60) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 60));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      edge_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      edge_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  task automatic send_item(input logic op, input logic [PIX_W-1:0] rgb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.opcode <= op;
    {pix.red_in, pix.green_in, pix.blue_in} <= rgb;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // wait for every predicted result, then let in-flight no-result items finish
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= sem_pkg::REG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_idx <= sem_pkg::REG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  // cut > 0 stops after that many pixels (partial frame)
  task automatic run_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input int noise, input int cut);
    int unsigned total, we;
    we = eff_dim(w, MAX_WIDTH);
    total = we * eff_dim(h, MAX_HEIGHT);
    set_size(w, h);
    for (int unsigned i = 0; i < total; i++) begin
      if (cut > 0 && i == unsigned'(cut)) return;
      if ($urandom_range(0, 99) < noise) send_item(sem_pkg::OP_DRAIN, PIX_W'($urandom));
      send_item(sem_pkg::OP_PIXEL, PIX_W'($urandom));
    end
    for (int unsigned i = 0; i <= we; i++) begin
      if ($urandom_range(0, 99) < noise) send_item(sem_pkg::OP_PIXEL, PIX_W'($urandom));
      send_item(sem_pkg::OP_DRAIN, PIX_W'($urandom));
    end
  endtask

  initial begin
    #8_000_000;
    $display("tb_sobel_edge_magnitude_rgb_core: errors");
    $finish;
  end

  initial begin
    logic [PIX_W-1:0] corner[9];
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.opcode = sem_pkg::OP_PIXEL;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;
    items_sent = 0;
    quiet = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 with extreme values, early drain, surplus pixel in the flush
    corner = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
               24'h000000, 24'hFF00FF, 24'h00FF00, 24'hAA55A5};
    set_size(11'd3, 11'd3);
    send_item(sem_pkg::OP_DRAIN, 24'hFFFFFF);
    foreach (corner[i]) send_item(sem_pkg::OP_PIXEL, corner[i]);
    send_item(sem_pkg::OP_DRAIN, 24'hFFFFFF);
    send_item(sem_pkg::OP_PIXEL, 24'h123456);
    repeat (3) send_item(sem_pkg::OP_DRAIN, 24'h5A5A5A);

    // zero sizes used as one, unknown register index ignored
    set_size(11'd0, 11'd0);
    cfg_we <= 1'b1;
    cfg_idx <= 2'd2;
    cfg_data <= '1;
    @(posedge clk_i);
    cfg_idx <= 2'd3;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    send_item(sem_pkg::OP_PIXEL, 24'hFFFFFF);
    send_item(sem_pkg::OP_DRAIN, '0);
    send_item(sem_pkg::OP_DRAIN, '0);

    while (items_sent < 1050) begin
      int r;
      quiet = ($urandom_range(0, 7) == 0);
      r = int'($urandom_range(0, 99));
      if (r < 75)
        run_frame(DIM_W'($urandom_range(1, 12)), DIM_W'($urandom_range(1, 8)), 5, 0);
      else if (r < 85)
        run_frame(DIM_W'($urandom_range(1, 12)), DIM_W'($urandom_range(1, 8)), 5,
                  int'($urandom_range(1, 20)));
      else if (r < 92)
        run_frame(DIM_W'($urandom_range(1, 3)), DIM_W'($urandom_range(1, 40)), 10, 0);
      else
        run_frame(DIM_W'($urandom_range(0, 1)), DIM_W'($urandom_range(0, 3)), 5, 0);
    end

    settle();
    if (errors == 0) begin
      $display("tb_sobel_edge_magnitude_rgb_core: clean");
    end else begin
      $display("tb_sobel_edge_magnitude_rgb_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
